// ===== hw/rtl/mrf_pkg.sv =====
// Shared constants, coefficient table and control types for the
// mean-removing symmetric FIR lowpass. No dependencies.
package mrf_pkg;

    localparam int MEAN_SHIFT_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int TAPS      = 17;
    localparam int HALF_TAPS = 8;
    localparam int FIR_SHIFT = 15;
    localparam int COEF_BITS = 13;

    // Half of the symmetric impulse response; the last entry is the center tap.
    localparam logic [COEF_BITS-1:0] FIR_COEF [HALF_TAPS+1] = '{
        13'd16, 13'd100, 13'd349, 13'd875, 13'd1703,
        13'd2729, 13'd3742, 13'd4489, 13'd4764
    };

    // Load enables for the filter datapath stages
    typedef struct packed {
        logic pair;
        logic prod;
        logic part;
        logic outp;
    } mrf_fir_en_t;

endpackage

// ===== hw/rtl/mrf_mean.sv =====
// Warm-up accumulator, running mean removal and 17-entry tap line.
// Depends on mrf_pkg.
module mrf_mean
    import mrf_pkg::*;
#(
    parameter int MEAN_SHIFT  = MEAN_SHIFT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ld,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS:0]   taps [TAPS]
);

    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int ACC_BITS  = SAMPLE_BITS + MEAN_SHIFT + 1;

    logic signed [ACC_BITS-1:0]  acc_reg;
    logic signed [ACC_BITS-1:0]  acc_next;
    logic signed [ACC_BITS-1:0]  mean;
    logic signed [ACC_BITS-1:0]  x_acc;
    logic [MEAN_SHIFT:0]         cnt_reg;
    logic [MEAN_SHIFT:0]         cnt_next;
    logic                        warm_done;
    logic signed [DIFF_BITS-1:0] x_diff;
    logic signed [DIFF_BITS-1:0] taps_reg [TAPS];

    // Counter saturates at 2^MEAN_SHIFT, so the top bit alone marks the end
    assign warm_done = cnt_reg[MEAN_SHIFT];

    always_comb
    begin
        x_acc = ACC_BITS'(sample);
        mean  = acc_reg >>> MEAN_SHIFT;
        if (warm_done)
        begin
            acc_next = acc_reg - mean + x_acc;
            x_diff   = DIFF_BITS'(x_acc - mean);
            cnt_next = cnt_reg;
        end
        else
        begin
            acc_next = acc_reg + x_acc;
            x_diff   = DIFF_BITS'(sample);
            cnt_next = cnt_reg + (MEAN_SHIFT+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
            for (int i = 0; i < TAPS; i++)
            begin
                taps_reg[i] <= '0;
            end
        end
        else if (ld)
        begin
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            taps_reg[0] <= x_diff;
            for (int i = 1; i < TAPS; i++)
            begin
                taps_reg[i] <= taps_reg[i-1];
            end
        end
    end

    assign taps = taps_reg;

endmodule

// ===== hw/rtl/mrf_fir.sv =====
// Symmetric 17-tap FIR datapath: pair adds, constant multiplies,
// two-level adder tree and final shift. Depends on mrf_pkg.
module mrf_fir
    import mrf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  mrf_fir_en_t                   en,
    input  logic signed [SAMPLE_BITS:0]   taps [TAPS],
    output logic signed [SAMPLE_BITS+1:0] filtered
);

    localparam int PAIR_BITS = SAMPLE_BITS + 2;
    localparam int PROD_BITS = PAIR_BITS + COEF_BITS + 1;
    localparam int SUM_BITS  = PROD_BITS + 4;
    localparam int OUT_BITS  = SAMPLE_BITS + 2;
    localparam int NPROD     = HALF_TAPS + 1;
    localparam int NPART     = 3;

    logic signed [PAIR_BITS-1:0] pair_reg [NPROD];
    logic signed [PROD_BITS-1:0] prod_reg [NPROD];
    logic signed [SUM_BITS-1:0]  part_reg [NPART];
    logic signed [SUM_BITS-1:0]  total;
    logic signed [OUT_BITS-1:0]  out_reg;

    assign total = part_reg[0] + part_reg[1] + part_reg[2];

    always_ff @(posedge clk)
    begin
        if (en.pair)
        begin
            for (int i = 0; i < HALF_TAPS; i++)
            begin
                pair_reg[i] <= PAIR_BITS'(taps[i]) + PAIR_BITS'(taps[TAPS-1-i]);
            end
            pair_reg[HALF_TAPS] <= PAIR_BITS'(taps[HALF_TAPS]);
        end
        if (en.prod)
        begin
            for (int i = 0; i < NPROD; i++)
            begin
                prod_reg[i] <= PROD_BITS'(pair_reg[i])
                             * PROD_BITS'($signed({1'b0, FIR_COEF[i]}));
            end
        end
        if (en.part)
        begin
            for (int k = 0; k < NPART; k++)
            begin
                part_reg[k] <= SUM_BITS'(prod_reg[3*k]) + SUM_BITS'(prod_reg[3*k+1])
                             + SUM_BITS'(prod_reg[3*k+2]);
            end
        end
        if (en.outp)
        begin
            // floor shift: drop the low bits of the two's complement sum
            out_reg <= total[FIR_SHIFT +: OUT_BITS];
        end
    end

    assign filtered = out_reg;

endmodule

// ===== hw/rtl/mean_removal_symmetric_fir_lowpass_top.sv =====
// Mean-removing 17-tap symmetric FIR lowpass, top level.
// Pipeline: a result is valid on m_axis once its input transaction has passed six
// registers (input, mean/tap stage, pair adds, multiplies, partial sums, output).
// Throughput: one transaction per cycle; a stage holds only while the next is full and stalled.
// Reset: rst_n asynchronous active low clears valid flags, accumulator, warm-up count, taps.
// Depends on mrf_pkg, mrf_mean, mrf_fir.
module mean_removal_symmetric_fir_lowpass_top
    import mrf_pkg::*;
#(
    parameter int MEAN_SHIFT  = MEAN_SHIFT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_BITS+2+7)/8)*8-1:0]    m_axis_tdata   // [SAMPLE_BITS+1:0] filtered
);

    localparam int OUT_TDATA_W = ((SAMPLE_BITS + 2 + 7) / 8) * 8;
    localparam int NSTAGE      = 6;

    // Stage 0 input register, stage 1 tap line, stages 2..5 filter datapath
    logic [NSTAGE-1:0]             vld_reg;
    logic [NSTAGE-1:0]             vld_next;
    logic [NSTAGE-1:0]             free;
    logic [NSTAGE-1:0]             take;
    logic [NSTAGE-1:0]             ld;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS:0]   taps [TAPS];
    logic signed [SAMPLE_BITS+1:0] filtered;
    mrf_fir_en_t                   fir_en;

    // Walk from the output back: a stage is free if empty or draining this cycle
    always_comb
    begin
        take[NSTAGE-1] = m_axis_tready;
        for (int k = NSTAGE - 1; k >= 0; k--)
        begin
            free[k] = !vld_reg[k] || take[k];
            if (k > 0)
            begin
                take[k-1] = vld_reg[k-1] && free[k];
            end
        end
        ld[0] = s_axis_tvalid && free[0];
        for (int k = 1; k < NSTAGE; k++)
        begin
            ld[k] = take[k-1];
        end
        for (int k = 0; k < NSTAGE; k++)
        begin
            vld_next[k] = free[k] ? ld[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Hold the accepted sample until the tap stage takes it
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            sample_reg <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
        end
    end

    mrf_mean #(
        .MEAN_SHIFT  (MEAN_SHIFT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mean (
        .clk    (clk),
        .rst_n  (rst_n),
        .ld     (ld[1]),
        .sample (sample_reg),
        .taps   (taps)
    );

    always_comb
    begin
        fir_en.pair = ld[2];
        fir_en.prod = ld[3];
        fir_en.part = ld[4];
        fir_en.outp = ld[5];
    end

    mrf_fir #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_fir (
        .clk      (clk),
        .en       (fir_en),
        .taps     (taps),
        .filtered (filtered)
    );

    assign s_axis_tready = free[0];
    assign m_axis_tvalid = vld_reg[NSTAGE-1];
    // Zero-fill the result up to whole bytes
    assign m_axis_tdata  = OUT_TDATA_W'($unsigned(filtered));

endmodule

// ===== hw/rtl/mrf_checker.sv =====
// Port-level checker for the mean-removing FIR lowpass and its bind.
// Depends on mrf_pkg and mean_removal_symmetric_fir_lowpass_top.
module mrf_checker
    import mrf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [((SAMPLE_BITS+2+7)/8)*8-1:0] m_axis_tdata
);

    localparam int MAX_INFLIGHT = 6;

    logic [3:0] inflight_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 4'(in_acc) - 4'(out_acc);
        end
    end

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // With no result waiting, every stage can move, so input must be ready
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 4'(MAX_INFLIGHT))
        else $error("more transactions in flight than pipeline stages");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == 4'd0 |-> !m_axis_tvalid)
        else $error("result shown with no transaction in flight");

endmodule

bind mean_removal_symmetric_fir_lowpass_top mrf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mrf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
